[sv/kmd_pkg.sv]
package kmd_pkg;

	localparam int ROWS_DEF = 4;
	localparam int COLS_DEF = 12;

	localparam int HIST_W  = 8;
	localparam int ENTRY_W = HIST_W + 1;
	localparam int CFG_IW  = 2;
	localparam int CFG_DW  = 16;

	localparam logic [CFG_IW-1:0] REG_PRESS_THR   = 2'd0;
	localparam logic [CFG_IW-1:0] REG_RELEASE_THR = 2'd1;
	localparam logic [CFG_IW-1:0] REG_ENC_IDLE    = 2'd2;

	localparam logic [7:0]  PRESS_THR_RST   = 8'd224;
	localparam logic [7:0]  RELEASE_THR_RST = 8'd0;
	localparam logic [15:0] ENC_IDLE_RST    = 16'd400;

	localparam logic [1:0] ENC_ROW      = 2'd3;
	localparam logic [3:0] ENC0_DIR1    = 4'd0;
	localparam logic [3:0] ENC0_DIR0    = 4'd4;
	localparam logic [3:0] ENC1_DIR1    = 4'd6;
	localparam logic [3:0] ENC1_DIR0    = 4'd11;
	localparam logic [3:0] ENC1_FIRST   = 4'd5;
	localparam logic [7:0] NORMAL_PRESS = 8'h80;
	localparam logic [2:0] PATTERN_ONES = 3'b111;
	localparam logic [5:0] COUNT_MAX    = 6'd63;

	typedef struct packed {
		logic        en;
		logic        enc;
		logic        dir;
		logic        phase;
		logic [15:0] now;
	} enc_req_t;

endpackage

[sv/kmd_row_mem.sv]
module kmd_row_mem
	import kmd_pkg::*;
#(
	parameter int ROWS   = ROWS_DEF,
	parameter int WORD_W = COLS_DEF * ENTRY_W,
	parameter int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              rd_en,
	input  logic [ROW_W-1:0]  rd_row,
	input  logic              wr_en,
	input  logic [ROW_W-1:0]  wr_row,
	input  logic [WORD_W-1:0] wr_data,
	output logic [WORD_W-1:0] rd_data
);

	logic [WORD_W-1:0] mem [ROWS];
	logic [ROWS-1:0]   vld_q;
	logic [WORD_W-1:0] rd_q;
	logic              rd_vld_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_row] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem[rd_row];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_row] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_q <= vld_q[rd_row];
			end
		end
	end

	// rows never written read as cleared
	assign rd_data = rd_vld_q ? rd_q : '0;

endmodule

[sv/kmd_encoder.sv]
module kmd_encoder
	import kmd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  enc_req_t    req,
	input  logic [7:0]  press_thr,
	input  logic [15:0] idle_ms,
	output logic [7:0]  pulse_val
);

	logic [3:0]  phase_prev_q;
	logic [2:0]  pattern_q;
	logic [15:0] last_step_q;

	logic [15:0] elapsed;
	logic [2:0]  target;
	logic [2:0]  base;
	logic [2:0]  shifted;
	logic [1:0]  own;
	logic [1:0]  other;
	logic        changed;
	logic        step;
	logic        pulse;

	always_comb begin
		elapsed = req.now - last_step_q;
		target  = req.dir ? PATTERN_ONES : 3'b000;
		base    = (elapsed > idle_ms) ? target : pattern_q;
		shifted = {base[1:0], req.dir};
		own     = {req.enc, req.dir};
		other   = {req.enc, ~req.dir};
		changed = req.phase != phase_prev_q[own];
		step    = changed && !req.phase && !phase_prev_q[other];
		pulse   = step && (shifted == target);
	end

	assign pulse_val = pulse ? press_thr : 8'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_prev_q <= '0;
			pattern_q    <= '0;
			last_step_q  <= '0;
		end else if (req.en) begin
			pattern_q <= step ? shifted : base;
			if (changed) begin
				phase_prev_q[own] <= req.phase;
			end
			if (pulse) begin
				last_step_q <= req.now;
			end
		end
	end

endmodule

[sv/key_matrix_debounce_encoder_core.sv]
// an accepted input transaction is registered in stage one, then its result in the output registers
// throughput: one transaction per cycle while out_stall does not hold the output, set by the row memory
// read-modify-write with forwarding of the row written in the same cycle
// reset: asynchronous, active low; clears histories via per-row valid bits,
// encoder state, count and registers to their defaults, no clearing pass
module key_matrix_debounce_encoder_core
	import kmd_pkg::*;
#(
	parameter int ROWS = ROWS_DEF,
	parameter int COLS = COLS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [CFG_IW-1:0] cfg_index,
	input  logic [CFG_DW-1:0] cfg_wdata,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [1:0]        key_row,
	input  logic [3:0]        key_col,
	input  logic              raw_pressed,
	input  logic [15:0]       now_ms,
	input  logic              scan_end,
	output logic              out_valid,
	input  logic              out_stall,
	output logic              key_state,
	output logic              key_active,
	output logic [5:0]        keys_down,
	output logic              scan_done
);

	localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int COL_W  = (COLS > 1) ? $clog2(COLS) : 1;
	localparam int WORD_W = COLS * ENTRY_W;

	logic [7:0]  press_thr_q;
	logic [7:0]  release_thr_q;
	logic [15:0] enc_idle_q;

	logic        s1_v;
	logic [1:0]  row_s1;
	logic [3:0]  col_s1;
	logic        raw_s1;
	logic [15:0] now_s1;
	logic        end_s1;
	logic        byp_s1;
	logic [COLS-1:0][ENTRY_W-1:0] fwd_q;

	logic [5:0]  count_q;
	logic        out_v_q;

	logic        adv;
	logic        accept;
	logic        in_mx;
	logic        enc_hit;
	logic        s1_wr;
	logic [ROW_W-1:0] rd_row;
	logic [ROW_W-1:0] wr_row;
	logic [COL_W-1:0] col_idx;
	logic [WORD_W-1:0] mem_rd;
	logic [COLS-1:0][ENTRY_W-1:0] cur_word;
	logic [COLS-1:0][ENTRY_W-1:0] new_word;
	logic [ENTRY_W-1:0] entry;
	logic [7:0]  hist_new;
	logic [7:0]  v;
	logic [7:0]  enc_v;
	logic        deb_new;
	logic [5:0]  count_new;
	enc_req_t    enc_req;

	assign adv      = !out_v_q || !out_stall;
	assign in_stall = s1_v && !adv;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			press_thr_q   <= PRESS_THR_RST;
			release_thr_q <= RELEASE_THR_RST;
			enc_idle_q    <= ENC_IDLE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_PRESS_THR:   press_thr_q   <= cfg_wdata[7:0];
				REG_RELEASE_THR: release_thr_q <= cfg_wdata[7:0];
				REG_ENC_IDLE:    enc_idle_q    <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		rd_row   = ROW_W'(key_row);
		wr_row   = ROW_W'(row_s1);
		col_idx  = COL_W'(col_s1);
		in_mx    = (int'(row_s1) < ROWS) && (int'(col_s1) < COLS);
		enc_hit  = (row_s1 == ENC_ROW) &&
			(col_s1 inside {ENC0_DIR1, ENC0_DIR0, ENC1_DIR1, ENC1_DIR0});
		s1_wr    = s1_v && adv && in_mx;
		cur_word = byp_s1 ? fwd_q : mem_rd;
		entry    = cur_word[col_idx];

		enc_req.en    = s1_wr && enc_hit;
		enc_req.enc   = col_s1 >= ENC1_FIRST;
		enc_req.dir   = (col_s1 == ENC0_DIR1) || (col_s1 == ENC1_DIR1);
		enc_req.phase = raw_s1;
		enc_req.now   = now_s1;

		v        = enc_hit ? enc_v : (raw_s1 ? NORMAL_PRESS : 8'd0);
		hist_new = {1'b0, entry[7:1]} | v;
		if (hist_new >= press_thr_q) begin
			deb_new = 1'b1;
		end else if (hist_new <= release_thr_q) begin
			deb_new = 1'b0;
		end else begin
			deb_new = entry[8];
		end
		new_word          = cur_word;
		new_word[col_idx] = {deb_new, hist_new};

		count_new = count_q;
		if (in_mx && (hist_new != 8'd0) && (count_q != COUNT_MAX)) begin
			count_new = count_q + 6'd1;
		end
	end

	kmd_row_mem #(
		.ROWS   (ROWS),
		.WORD_W (WORD_W),
		.ROW_W  (ROW_W)
	) u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.rd_row  (rd_row),
		.wr_en   (s1_wr),
		.wr_row  (wr_row),
		.wr_data (new_word),
		.rd_data (mem_rd)
	);

	kmd_encoder u_enc (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (enc_req),
		.press_thr (press_thr_q),
		.idle_ms   (enc_idle_q),
		.pulse_val (enc_v)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v    <= 1'b0;
			byp_s1  <= 1'b0;
			count_q <= '0;
			out_v_q <= 1'b0;
		end else begin
			if (accept) begin
				s1_v   <= 1'b1;
				byp_s1 <= s1_wr && (row_s1 == key_row);
			end else if (adv) begin
				s1_v <= 1'b0;
			end
			if (s1_v && adv) begin
				count_q <= end_s1 ? 6'd0 : count_new;
				out_v_q <= 1'b1;
			end else if (adv) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			row_s1 <= key_row;
			col_s1 <= key_col;
			raw_s1 <= raw_pressed;
			now_s1 <= now_ms;
			end_s1 <= scan_end;
		end
		if (s1_wr) begin
			fwd_q <= new_word;
		end
		if (s1_v && adv) begin
			key_state  <= in_mx && deb_new;
			key_active <= in_mx && (hist_new != 8'd0);
			keys_down  <= count_new;
			scan_done  <= end_s1;
		end
	end

	assign out_valid = out_v_q;

`ifndef SYNTHESIS
	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (s1_v && out_v_q && out_stall))
		else $error("input stalled while pipeline can move");

	a_pulse_only_on_encoder: assert property (@(posedge clk) disable iff (!arst_n)
		enc_req.en |-> (in_mx && enc_hit && s1_v))
		else $error("encoder update outside encoder columns");

	a_count_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_v && adv && end_s1) |=> (count_q == 6'd0))
		else $error("keys-down count not cleared after scan end");
`endif

endmodule
